[rtl/rgcc_pkg.sv]
// Shared types and fixed widths for the rectangle-to-grid-cell cover block.
`timescale 1ns / 1ps

package rgcc_pkg;

   localparam int CoordW      = 20;
   localparam int WideW       = 22;
   localparam int CellW       = 16;
   localparam int ShW         = 5;
   localparam int CfgW        = 4;
   localparam int CfgReset    = 5;
   localparam int CellLog2Max = 10;

   typedef logic signed [CoordW-1:0] coord_type;
   typedef logic signed [WideW-1:0]  wide_type;
   typedef logic signed [CellW-1:0]  cell_type;
   typedef logic [ShW-1:0]           shamt_type;
   typedef logic [CfgW-1:0]          cfg_type;

   // one operation of the shared add-and-shift unit
   typedef struct packed {
      wide_type  a;
      wide_type  b;
      logic      sub;
      logic      dec;
      shamt_type shamt;
   } alu_op_type;

   // launch of a cell walk
   typedef struct packed {
      logic     start;
      logic     clip;
      cell_type base_x;
      cell_type base_y;
   } emit_ctl_type;

endpackage

[rtl/rgcc_alu.sv]
// Shared adder with arithmetic right shift, used for every edge and span step.
`timescale 1ns / 1ps

module rgcc_alu (
   input  rgcc_pkg::alu_op_type op,
   output rgcc_pkg::wide_type   result
);
   import rgcc_pkg::*;

   wide_type b_term;
   wide_type sum;

   always_comb begin
      // subtract as add of the complement plus one; dec takes one LSB off
      b_term = op.sub ? ~op.b : op.b;
      sum    = op.a + b_term + wide_type'({1'b0, op.sub}) - wide_type'({1'b0, op.dec});
      result = sum >>> op.shamt;
   end

endmodule

[rtl/rgcc_emitter.sv]
// Row and column walk over the covered cells, one registered word per cycle.
`timescale 1ns / 1ps

module rgcc_emitter #(
   parameter int SPAN_W = 3
) (
   input  logic                   clock,
   input  logic                   reset,
   input  rgcc_pkg::emit_ctl_type ctl,
   input  logic [SPAN_W-1:0]      col_last,
   input  logic [SPAN_W-1:0]      row_last,
   output logic                   finish,
   output logic                   strobe,
   output rgcc_pkg::cell_type     cell_x,
   output rgcc_pkg::cell_type     cell_y,
   output logic                   is_last,
   output logic                   clipped
);
   import rgcc_pkg::*;

   logic              active_ff, active_in;
   logic [SPAN_W-1:0] col_ff, col_in;
   logic [SPAN_W-1:0] row_ff, row_in;
   logic [SPAN_W-1:0] col_last_ff, col_last_in;
   logic [SPAN_W-1:0] row_last_ff, row_last_in;
   cell_type          base_x_ff, base_x_in;
   cell_type          base_y_ff, base_y_in;
   logic              clip_ff, clip_in;
   logic              strobe_ff, strobe_in;
   cell_type          cell_x_ff, cell_x_in;
   cell_type          cell_y_ff, cell_y_in;
   logic              is_last_ff, is_last_in;
   logic              clipped_ff, clipped_in;
   logic              col_end;
   logic              at_last;

   always_comb begin
      col_end = (col_ff == col_last_ff);
      at_last = active_ff && col_end && (row_ff == row_last_ff);

      active_in   = active_ff;
      col_in      = col_ff;
      row_in      = row_ff;
      col_last_in = col_last_ff;
      row_last_in = row_last_ff;
      base_x_in   = base_x_ff;
      base_y_in   = base_y_ff;
      clip_in     = clip_ff;

      // output word for the current position
      strobe_in  = active_ff;
      cell_x_in  = base_x_ff + CellW'(col_ff);
      cell_y_in  = base_y_ff + CellW'(row_ff);
      is_last_in = at_last;
      clipped_in = clip_ff;

      if (ctl.start) begin
         active_in   = 1'b1;
         col_in      = '0;
         row_in      = '0;
         col_last_in = col_last;
         row_last_in = row_last;
         base_x_in   = ctl.base_x;
         base_y_in   = ctl.base_y;
         clip_in     = ctl.clip;
      end else if (active_ff) begin
         // advance along the row, wrap to the next row
         if (at_last) begin
            active_in = 1'b0;
         end else if (col_end) begin
            col_in = '0;
            row_in = row_ff + SPAN_W'(1);
         end else begin
            col_in = col_ff + SPAN_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         strobe_ff <= 1'b0;
      end else begin
         active_ff <= active_in;
         strobe_ff <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      col_ff      <= col_in;
      row_ff      <= row_in;
      col_last_ff <= col_last_in;
      row_last_ff <= row_last_in;
      base_x_ff   <= base_x_in;
      base_y_ff   <= base_y_in;
      clip_ff     <= clip_in;
      cell_x_ff   <= cell_x_in;
      cell_y_ff   <= cell_y_in;
      is_last_ff  <= is_last_in;
      clipped_ff  <= clipped_in;
   end

   assign finish  = at_last;
   assign strobe  = strobe_ff;
   assign cell_x  = cell_x_ff;
   assign cell_y  = cell_y_ff;
   assign is_last = is_last_ff;
   assign clipped = clipped_ff;

endmodule

[rtl/rect_grid_cell_cover_unit.sv]
// Top level: rectangle to grid cell cover with a shared add-and-shift unit.
`timescale 1ns / 1ps

//  channel   | ports                                  | handshake
//  ----------+----------------------------------------+----------------------------
//  request   | req_rect_x/y/w/h, req_fallback_cell_x/y | start high, busy low
//  response  | rsp_cell_x/y, rsp_is_last, rsp_clipped  | rsp_strobe, one cycle
//  config    | csr_wr_data                            | csr_wr_en, no wait
//
// A non-empty rectangle keeps busy high through six steps of the shared
// add-and-shift unit (two left/top edges, two right/bottom edges, two spans),
// then through the emitter walk over the covered cells.
// An empty rectangle goes straight to a one-cell walk and yields its fallback word.
// Each word shows on the response ports in the cycle after the emitter reaches it.
// Reset is synchronous; it idles the sequencer and emitter and sets the cell size
// register to 5. The receiver cannot stall, so words are never held back.

module rect_grid_cell_cover_unit #(
   parameter int MAX_SPAN        = 8,
   parameter int COORD_FRAC_BITS = 4
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  rgcc_pkg::coord_type req_rect_x,
   input  rgcc_pkg::coord_type req_rect_y,
   input  rgcc_pkg::coord_type req_rect_w,
   input  rgcc_pkg::coord_type req_rect_h,
   input  rgcc_pkg::cell_type  req_fallback_cell_x,
   input  rgcc_pkg::cell_type  req_fallback_cell_y,
   output logic                rsp_strobe,
   output rgcc_pkg::cell_type  rsp_cell_x,
   output rgcc_pkg::cell_type  rsp_cell_y,
   output logic                rsp_is_last,
   output logic                rsp_clipped,
   input  logic                csr_wr_en,
   input  rgcc_pkg::cfg_type   csr_wr_data
);
   import rgcc_pkg::*;

   localparam int SpanW = (MAX_SPAN > 1) ? $clog2(MAX_SPAN) : 1;

   localparam wide_type         SpanMax  = wide_type'(MAX_SPAN - 1);
   localparam logic [SpanW-1:0] SpanTop  = SpanW'(MAX_SPAN - 1);

   typedef enum logic [7:0] {
      S_IDLE = 8'b0000_0001,
      S_X0   = 8'b0000_0010,
      S_Y0   = 8'b0000_0100,
      S_X1   = 8'b0000_1000,
      S_Y1   = 8'b0001_0000,
      S_NX   = 8'b0010_0000,
      S_NY   = 8'b0100_0000,
      S_EMIT = 8'b1000_0000
   } state_type;

   state_type        state_ff, state_in;
   cfg_type          cfg_log2_ff, cfg_log2_in;
   shamt_type        shamt_ff, shamt_in;
   coord_type        rect_x_ff, rect_x_in;
   coord_type        rect_y_ff, rect_y_in;
   coord_type        rect_w_ff, rect_w_in;
   coord_type        rect_h_ff, rect_h_in;
   wide_type         x0_ff, x0_in;
   wide_type         y0_ff, y0_in;
   wide_type         x1_ff, x1_in;
   wide_type         y1_ff, y1_in;
   logic [SpanW-1:0] nx_last_ff, nx_last_in;
   logic             clip_x_ff, clip_x_in;

   alu_op_type       alu_op;
   wide_type         alu_res;
   emit_ctl_type     emit_ctl;
   logic [SpanW-1:0] emit_col_last;
   logic [SpanW-1:0] emit_row_last;
   logic             emit_finish;
   logic             accept;
   logic             is_empty;
   logic             span_over;
   cfg_type          log2_clamped;

   assign accept   = start && (state_ff == S_IDLE);
   assign is_empty = (req_rect_w <= coord_type'(0)) || (req_rect_h <= coord_type'(0));
   assign busy     = (state_ff != S_IDLE);

   // register values above the largest cell size act as the largest
   assign log2_clamped = (cfg_log2_ff > CfgW'(CellLog2Max)) ? CfgW'(CellLog2Max)
                                                             : cfg_log2_ff;

   // operand select for the shared unit
   always_comb begin
      alu_op       = '0;
      alu_op.shamt = shamt_ff;
      case (state_ff)
         S_X0: begin
            alu_op.a = wide_type'(rect_x_ff);
         end
         S_Y0: begin
            alu_op.a = wide_type'(rect_y_ff);
         end
         S_X1: begin
            // exclusive right edge: last covered LSB is x + w - 1
            alu_op.a   = wide_type'(rect_x_ff);
            alu_op.b   = wide_type'(rect_w_ff);
            alu_op.dec = 1'b1;
         end
         S_Y1: begin
            alu_op.a   = wide_type'(rect_y_ff);
            alu_op.b   = wide_type'(rect_h_ff);
            alu_op.dec = 1'b1;
         end
         S_NX: begin
            alu_op.a     = x1_ff;
            alu_op.b     = x0_ff;
            alu_op.sub   = 1'b1;
            alu_op.shamt = '0;
         end
         S_NY: begin
            alu_op.a     = y1_ff;
            alu_op.b     = y0_ff;
            alu_op.sub   = 1'b1;
            alu_op.shamt = '0;
         end
         default: begin
            alu_op = '0;
         end
      endcase
   end

   rgcc_alu u_alu (
      .op     (alu_op),
      .result (alu_res)
   );

   // span minus one above MAX_SPAN - 1 means the axis gets cut
   assign span_over = (alu_res > SpanMax);

   always_comb begin
      state_in    = state_ff;
      cfg_log2_in = csr_wr_en ? csr_wr_data : cfg_log2_ff;
      shamt_in    = shamt_ff;
      rect_x_in   = rect_x_ff;
      rect_y_in   = rect_y_ff;
      rect_w_in   = rect_w_ff;
      rect_h_in   = rect_h_ff;
      x0_in       = x0_ff;
      y0_in       = y0_ff;
      x1_in       = x1_ff;
      y1_in       = y1_ff;
      nx_last_in  = nx_last_ff;
      clip_x_in   = clip_x_ff;

      emit_ctl      = '0;
      emit_col_last = '0;
      emit_row_last = '0;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               rect_x_in = req_rect_x;
               rect_y_in = req_rect_y;
               rect_w_in = req_rect_w;
               rect_h_in = req_rect_h;
               shamt_in  = ShW'(log2_clamped) + ShW'(COORD_FRAC_BITS);
               if (is_empty) begin
                  // single fallback word, walk of one cell
                  emit_ctl.start  = 1'b1;
                  emit_ctl.base_x = req_fallback_cell_x;
                  emit_ctl.base_y = req_fallback_cell_y;
                  state_in        = S_EMIT;
               end else begin
                  state_in = S_X0;
               end
            end
         end
         S_X0: begin
            x0_in    = alu_res;
            state_in = S_Y0;
         end
         S_Y0: begin
            y0_in    = alu_res;
            state_in = S_X1;
         end
         S_X1: begin
            x1_in    = alu_res;
            state_in = S_Y1;
         end
         S_Y1: begin
            y1_in    = alu_res;
            state_in = S_NX;
         end
         S_NX: begin
            clip_x_in  = span_over;
            nx_last_in = span_over ? SpanTop : alu_res[SpanW-1:0];
            state_in   = S_NY;
         end
         S_NY: begin
            // launch the walk; indices wrap to the cell field width
            emit_ctl.start  = 1'b1;
            emit_ctl.clip   = clip_x_ff || span_over;
            emit_ctl.base_x = x0_ff[CellW-1:0];
            emit_ctl.base_y = y0_ff[CellW-1:0];
            emit_col_last   = nx_last_ff;
            emit_row_last   = span_over ? SpanTop : alu_res[SpanW-1:0];
            state_in        = S_EMIT;
         end
         S_EMIT: begin
            if (emit_finish) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         cfg_log2_ff <= CfgW'(CfgReset);
      end else begin
         state_ff    <= state_in;
         cfg_log2_ff <= cfg_log2_in;
      end
   end

   always_ff @(posedge clock) begin
      shamt_ff   <= shamt_in;
      rect_x_ff  <= rect_x_in;
      rect_y_ff  <= rect_y_in;
      rect_w_ff  <= rect_w_in;
      rect_h_ff  <= rect_h_in;
      x0_ff      <= x0_in;
      y0_ff      <= y0_in;
      x1_ff      <= x1_in;
      y1_ff      <= y1_in;
      nx_last_ff <= nx_last_in;
      clip_x_ff  <= clip_x_in;
   end

   rgcc_emitter #(
      .SPAN_W (SpanW)
   ) u_emitter (
      .clock    (clock),
      .reset    (reset),
      .ctl      (emit_ctl),
      .col_last (emit_col_last),
      .row_last (emit_row_last),
      .finish   (emit_finish),
      .strobe   (rsp_strobe),
      .cell_x   (rsp_cell_x),
      .cell_y   (rsp_cell_y),
      .is_last  (rsp_is_last),
      .clipped  (rsp_clipped)
   );

endmodule

[rtl/rgcc_checker.sv]
// Port-level checks on the cover unit, bound to the top level.
`timescale 1ns / 1ps

module rgcc_checker (
   input logic                clock,
   input logic                reset,
   input logic                start,
   input logic                busy,
   input rgcc_pkg::coord_type req_rect_w,
   input rgcc_pkg::coord_type req_rect_h,
   input logic                rsp_strobe,
   input logic                rsp_is_last,
   input logic                rsp_clipped
);
   import rgcc_pkg::*;

   // a word only follows a cycle of work
   a_strobe_after_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(busy))
      else $error("response word without preceding work");

   // empty rectangle gives its fallback word after accept, via the emitter's active and output registers
   a_empty_fallback: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && ((req_rect_w <= coord_type'(0)) || (req_rect_h <= coord_type'(0))))
      |-> ##2 (rsp_strobe && rsp_is_last && !rsp_clipped))
      else $error("empty rectangle did not yield a single fallback word");

   // words of one rectangle come back to back with one clip flag
   a_burst_contiguous: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_is_last) |=> (rsp_strobe && $stable(rsp_clipped)))
      else $error("gap or clip change inside a rectangle's words");

   // the last word is followed by a quiet cycle
   a_gap_after_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_is_last) |=> !rsp_strobe)
      else $error("word right after the last word");

   // going idle coincides with the last word
   a_idle_on_last: assert property (@(posedge clock) disable iff (reset)
      $fell(busy) |-> (rsp_strobe && rsp_is_last))
      else $error("went idle without delivering the last word");

endmodule

bind rect_grid_cell_cover_unit rgcc_checker u_checker (.*);
